// ----- rtl/kapb_pkg.sv -----
// types, constants and codes shared by the keyframe aligned packet prebuffer
package kapb_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int HANDLE_W   = 32;
    localparam int TICKS_W    = 32;
    localparam int TICK_W     = 40;
    localparam int DUR_W      = 48;
    localparam int GROUPS_W   = 4;
    localparam int STREAM_W   = 8;
    localparam int COUNT_W    = 7;
    localparam int TOTAL_W    = 63;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 112;
    localparam int HALF_TICK_W = TICK_W / 2;
    localparam int PART_W     = TICKS_W + HALF_TICK_W;
    localparam int PROD_W     = TICKS_W + TICK_W;

    localparam logic [DUR_W-1:0] DUR_MAX        = {DUR_W{1'b1}};
    localparam logic [DUR_W-1:0] UNKNOWN_DUR_PS = 48'd50000000000;

    localparam logic [GROUPS_W-1:0] GROUPS_RESET = 4'd2;
    localparam logic [TICK_W-1:0]   TICK_RESET   = 40'd11111111;
    localparam logic [STREAM_W-1:0] STREAM_RESET = 8'd0;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GROUPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_CLEAR,
        OP_READ,
        OP_STATUS
    } op_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL_HI,
        F_SUM,
        F_ENQ
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TRIM1,
        B_TRIM2,
        B_TRIM3,
        B_APPEND,
        B_EMIT,
        B_READ
    } back_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [STREAM_W-1:0] stream_sel;
        logic [HANDLE_W-1:0] packet_handle;
        logic                is_keyframe;
        logic [TICKS_W-1:0]  duration_ticks;
    } item_t;

    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] handle;
        logic                key;
        logic [DUR_W-1:0]    dur;
    } job_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                handle_valid;
        logic                last;
        logic [COUNT_W-1:0]  entry_count;
        logic [COUNT_W-1:0]  keyframe_count;
        logic [TOTAL_W-1:0]  total_duration_ps;
        logic                overflow;
    } result_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

// ----- rtl/kapb_front.sv -----
// front end: accepts words, classifies them and scales the packet duration to picoseconds
module kapb_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  kapb_pkg::item_t                 item,
    input  logic [kapb_pkg::TICK_W-1:0]     tick_length_ps,
    input  logic [kapb_pkg::STREAM_W-1:0]   video_stream,
    input  kapb_pkg::queue_status_t         q_status,
    output logic                            q_push,
    output kapb_pkg::job_t                  q_job
);

    kapb_pkg::front_state_t state_reg, state_next;
    kapb_pkg::op_t op_reg, op_next;
    logic [kapb_pkg::HANDLE_W-1:0] handle_reg, handle_next;
    logic                          key_reg, key_next;
    logic [kapb_pkg::TICKS_W-1:0]  ticks_reg, ticks_next;
    logic [kapb_pkg::PART_W-1:0]   plo_reg, plo_next;
    logic [kapb_pkg::PART_W-1:0]   phi_reg, phi_next;
    logic [kapb_pkg::DUR_W-1:0]    dur_reg, dur_next;
    logic [kapb_pkg::PROD_W-1:0]   prod;
    kapb_pkg::op_t                 in_op;

    assign in_ready = (state_reg == kapb_pkg::F_IDLE);

    always_comb
    begin
        case (item.command)
            kapb_pkg::CMD_CLEAR: in_op = kapb_pkg::OP_CLEAR;
            kapb_pkg::CMD_READ:  in_op = kapb_pkg::OP_READ;
            kapb_pkg::CMD_PUSH:
            begin
                in_op = (item.stream_sel == video_stream) ? kapb_pkg::OP_PUSH
                                                          : kapb_pkg::OP_STATUS;
            end
            default:             in_op = kapb_pkg::OP_STATUS;
        endcase
    end

    assign prod = kapb_pkg::PROD_W'(plo_reg)
                + {phi_reg, {kapb_pkg::HALF_TICK_W{1'b0}}};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        handle_next = handle_reg;
        key_next    = key_reg;
        ticks_next  = ticks_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        dur_next    = dur_reg;
        q_push      = 1'b0;
        case (state_reg)
            kapb_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_op;
                    handle_next = item.packet_handle;
                    key_next    = item.is_keyframe;
                    ticks_next  = item.duration_ticks;
                    plo_next    = kapb_pkg::PART_W'(item.duration_ticks)
                                * kapb_pkg::PART_W'(tick_length_ps[kapb_pkg::HALF_TICK_W-1:0]);
                    state_next  = (in_op == kapb_pkg::OP_PUSH) ? kapb_pkg::F_MUL_HI
                                                               : kapb_pkg::F_ENQ;
                end
            end
            kapb_pkg::F_MUL_HI:
            begin
                phi_next   = kapb_pkg::PART_W'(ticks_reg)
                           * kapb_pkg::PART_W'(tick_length_ps[kapb_pkg::TICK_W-1:
                                                              kapb_pkg::HALF_TICK_W]);
                state_next = kapb_pkg::F_SUM;
            end
            kapb_pkg::F_SUM:
            begin
                if (ticks_reg == '0)
                begin
                    dur_next = kapb_pkg::UNKNOWN_DUR_PS;
                end
                else if (|prod[kapb_pkg::PROD_W-1:kapb_pkg::DUR_W])
                begin
                    dur_next = kapb_pkg::DUR_MAX;
                end
                else
                begin
                    dur_next = prod[kapb_pkg::DUR_W-1:0];
                end
                state_next = kapb_pkg::F_ENQ;
            end
            kapb_pkg::F_ENQ:
            begin
                if (!q_status.full)
                begin
                    q_push     = 1'b1;
                    state_next = kapb_pkg::F_IDLE;
                end
            end
            default: state_next = kapb_pkg::F_IDLE;
        endcase
    end

    assign q_job = '{op: op_reg, handle: handle_reg, key: key_reg, dur: dur_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kapb_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        handle_reg <= handle_next;
        key_reg    <= key_next;
        ticks_reg  <= ticks_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        dur_reg    <= dur_next;
    end

endmodule

// ----- rtl/kapb_queue.sv -----
// two-entry job queue between front end and back end
module kapb_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  kapb_pkg::job_t          push_job,
    input  logic                    pop,
    output kapb_pkg::job_t          pop_job,
    output kapb_pkg::queue_status_t status
);

    kapb_pkg::job_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign status.valid = (cnt_reg != 2'd0);
    assign status.full  = (cnt_reg == 2'd2);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign pop_job      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/kapb_back.sv -----
// back end: ring store of packet descriptors, trim sequencer, read out and result register
module kapb_back
#(
    parameter int CAPACITY = kapb_pkg::CAPACITY_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [kapb_pkg::GROUPS_W-1:0]   keyframe_groups,
    input  kapb_pkg::queue_status_t         q_status,
    input  kapb_pkg::job_t                  q_job,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output kapb_pkg::result_t               result
);

    localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TW = kapb_pkg::DUR_W + CW;
    localparam logic [AW:0]   CAP_SUM  = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

    kapb_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] kf_reg, kf_next;
    logic [TW-1:0] total_reg, total_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    kapb_pkg::job_t    job_reg, job_next;
    logic              out_valid_reg, out_valid_next;
    kapb_pkg::result_t res_reg, res_next;

    logic [kapb_pkg::HANDLE_W-1:0] hmem [CAPACITY];
    logic                          fmem [CAPACITY];
    logic [kapb_pkg::DUR_W-1:0]    dmem [CAPACITY];
    logic                          flag_rd_reg;
    logic [kapb_pkg::DUR_W-1:0]    dur_rd_reg;
    logic [kapb_pkg::HANDLE_W-1:0] handle_rd_reg;

    logic [AW:0]               tail_sum;
    logic [AW-1:0]             tail;
    logic [AW-1:0]             head_inc;
    logic [AW-1:0]             ptr_inc;
    logic [kapb_pkg::GROUPS_W-1:0] groups_eff;
    logic                      slot_free;
    logic                      rd_last;
    logic                      wr_en;

    assign tail_sum   = (AW + 1)'(head_reg) + (AW + 1)'(occ_reg);
    assign tail       = (tail_sum >= CAP_SUM) ? AW'(tail_sum - CAP_SUM) : AW'(tail_sum);
    assign head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign ptr_inc    = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
    assign groups_eff = (keyframe_groups == '0) ? kapb_pkg::GROUPS_W'(1) : keyframe_groups;
    assign slot_free  = !out_valid_reg || out_ready;
    assign rd_last    = (CW'(cnt_reg + 1'b1) == occ_reg);

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        kf_next        = kf_reg;
        total_next     = total_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        case (state_reg)
            kapb_pkg::B_IDLE:
            begin
                if (q_status.valid)
                begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    ovf_next = 1'b0;
                    case (q_job.op)
                        kapb_pkg::OP_CLEAR:
                        begin
                            head_next  = '0;
                            occ_next   = '0;
                            kf_next    = '0;
                            total_next = '0;
                            state_next = kapb_pkg::B_EMIT;
                        end
                        kapb_pkg::OP_READ:
                        begin
                            ptr_next   = head_reg;
                            cnt_next   = '0;
                            state_next = (occ_reg == '0) ? kapb_pkg::B_EMIT : kapb_pkg::B_READ;
                        end
                        kapb_pkg::OP_PUSH:
                        begin
                            state_next = q_job.key ? kapb_pkg::B_TRIM1 : kapb_pkg::B_TRIM3;
                        end
                        default: state_next = kapb_pkg::B_EMIT;
                    endcase
                end
            end
            kapb_pkg::B_TRIM1:
            begin
                if (occ_reg != '0 && 8'(kf_reg) >= 8'(groups_eff))
                begin
                    head_next  = head_inc;
                    occ_next   = occ_reg - 1'b1;
                    kf_next    = kf_reg - CW'(flag_rd_reg);
                    total_next = total_reg - TW'(dur_rd_reg);
                end
                else
                begin
                    state_next = kapb_pkg::B_TRIM2;
                end
            end
            kapb_pkg::B_TRIM2:
            begin
                if (occ_reg != '0 && !flag_rd_reg)
                begin
                    head_next  = head_inc;
                    occ_next   = occ_reg - 1'b1;
                    total_next = total_reg - TW'(dur_rd_reg);
                end
                else
                begin
                    state_next = kapb_pkg::B_TRIM3;
                end
            end
            kapb_pkg::B_TRIM3:
            begin
                if (occ_reg == CAP_CNT)
                begin
                    head_next  = head_inc;
                    occ_next   = occ_reg - 1'b1;
                    kf_next    = kf_reg - CW'(flag_rd_reg);
                    total_next = total_reg - TW'(dur_rd_reg);
                    ovf_next   = 1'b1;
                end
                else
                begin
                    state_next = kapb_pkg::B_APPEND;
                end
            end
            kapb_pkg::B_APPEND:
            begin
                wr_en      = 1'b1;
                occ_next   = occ_reg + 1'b1;
                kf_next    = kf_reg + CW'(job_reg.key);
                total_next = total_reg + TW'(job_reg.dur);
                state_next = kapb_pkg::B_EMIT;
            end
            kapb_pkg::B_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    res_next = '{handle_out: '0, handle_valid: 1'b0, last: 1'b1,
                                 entry_count: kapb_pkg::COUNT_W'(occ_reg),
                                 keyframe_count: kapb_pkg::COUNT_W'(kf_reg),
                                 total_duration_ps: kapb_pkg::TOTAL_W'(total_reg),
                                 overflow: ovf_reg};
                    state_next = kapb_pkg::B_IDLE;
                end
            end
            kapb_pkg::B_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    res_next = '{handle_out: handle_rd_reg, handle_valid: 1'b1, last: rd_last,
                                 entry_count: kapb_pkg::COUNT_W'(occ_reg),
                                 keyframe_count: kapb_pkg::COUNT_W'(kf_reg),
                                 total_duration_ps: kapb_pkg::TOTAL_W'(total_reg),
                                 overflow: 1'b0};
                    ptr_next = ptr_inc;
                    cnt_next = cnt_reg + 1'b1;
                    if (rd_last)
                    begin
                        state_next = kapb_pkg::B_IDLE;
                    end
                end
            end
            default: state_next = kapb_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kapb_pkg::B_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            kf_reg        <= '0;
            total_reg     <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            kf_reg        <= kf_next;
            total_reg     <= total_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        res_reg <= res_next;
    end

    // head entry is read ahead so trims drop one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hmem[tail] <= job_reg.handle;
            fmem[tail] <= job_reg.key;
            dmem[tail] <= job_reg.dur;
        end
        if (wr_en && tail == head_next)
        begin
            flag_rd_reg <= job_reg.key;
            dur_rd_reg  <= job_reg.dur;
        end
        else
        begin
            flag_rd_reg <= fmem[head_next];
            dur_rd_reg  <= dmem[head_next];
        end
        handle_rd_reg <= hmem[ptr_next];
    end

    a_kf_within_occ: assert property (@(posedge clk) disable iff (!rst_n)
        kf_reg <= occ_reg)
        else $error("keyframe count exceeds occupancy");

    a_occ_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_CNT)
        else $error("occupancy exceeds capacity");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (total_reg == '0))
        else $error("empty store with nonzero duration total");

    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kapb_pkg::B_READ && slot_free && rd_last)
        |=> (state_reg == kapb_pkg::B_IDLE && out_valid_reg && res_reg.last))
        else $error("read out did not end on the last entry");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kapb_pkg::B_APPEND) |-> (occ_reg < CAP_CNT))
        else $error("append into a full store");

endmodule

// ----- rtl/keyframe_aligned_packet_prebuffer_core.sv -----
// top level of the keyframe aligned packet prebuffer: config registers and stream ports
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  s_tdata packet fields, s_tuser command
//  m_*      out        m_tvalid/m_tready  m_tdata status and handle, m_tlast
//  cfg_*    in         cfg_we             cfg_index, cfg_wdata
//
// the front end takes one word at a time and scales pushes (two 32x20 partial products, a sum)
// back end: keyframe pushes trim1, trim2, trim3, append; others trim3 (overflow drop), append
// clear and status words go to emit, a read out one handle per cycle while m_tready is high
// reset initialises counts, pointers, flags and config; the stores need no clearing pass
// the two-entry job queue lets the front end take a word while a result waits on m_tready
module keyframe_aligned_packet_prebuffer_core
#(
    parameter int CAPACITY = kapb_pkg::CAPACITY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // stream_sel, packet_handle, is_keyframe, duration_ticks, zero pad
    input  logic [kapb_pkg::IN_DATA_W-1:0]    s_tdata,
    // command
    input  logic [kapb_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // handle_out, handle_valid, entry_count, keyframe_count, total_duration_ps,
    // overflow, zero pad
    output logic [kapb_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [kapb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kapb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [kapb_pkg::GROUPS_W-1:0] groups_reg;
    logic [kapb_pkg::TICK_W-1:0]   tick_reg;
    logic [kapb_pkg::STREAM_W-1:0] stream_reg;

    kapb_pkg::item_t         item;
    kapb_pkg::queue_status_t q_status;
    kapb_pkg::job_t          push_job;
    kapb_pkg::job_t          pop_job;
    kapb_pkg::result_t       result;
    logic                    q_push;
    logic                    q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg <= kapb_pkg::GROUPS_RESET;
            tick_reg   <= kapb_pkg::TICK_RESET;
            stream_reg <= kapb_pkg::STREAM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kapb_pkg::REG_GROUPS: groups_reg <= cfg_wdata[kapb_pkg::GROUPS_W-1:0];
                kapb_pkg::REG_TICK:   tick_reg   <= cfg_wdata[kapb_pkg::TICK_W-1:0];
                kapb_pkg::REG_STREAM: stream_reg <= cfg_wdata[kapb_pkg::STREAM_W-1:0];
                default:              groups_reg <= groups_reg;
            endcase
        end
    end

    assign item = '{command:        s_tuser,
                    stream_sel:     s_tdata[7:0],
                    packet_handle:  s_tdata[39:8],
                    is_keyframe:    s_tdata[40],
                    duration_ticks: s_tdata[72:41]};

    kapb_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .item           (item),
        .tick_length_ps (tick_reg),
        .video_stream   (stream_reg),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    kapb_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    kapb_back #(.CAPACITY(CAPACITY)) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .keyframe_groups (groups_reg),
        .q_status        (q_status),
        .q_job           (pop_job),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .result          (result)
    );

    assign m_tlast = result.last;
    assign m_tdata = {1'b0,
                      result.overflow,
                      result.total_duration_ps,
                      result.keyframe_count,
                      result.entry_count,
                      result.handle_valid,
                      result.handle_out};

endmodule
